// File: design/centered_moving_average_defines.svh
`ifndef CENTERED_MOVING_AVERAGE_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent, except while in reset.
`define CMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle that follows a reset cycle.
`define CMA_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// File: design/cma_pkg.sv
`timescale 1ns / 1ps

package cma_pkg;

   // Width and reset value of the window size register.
   localparam int                    WINDOW_W     = 7;
   localparam logic [WINDOW_W-1:0]   WINDOW_RESET = WINDOW_W'(5);

   // Sequencer states: wait for an item, fold it into the window sum,
   // wait for the divider, drop the oldest sample during the flush.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_WAIT,
      ST_SUB
   } cma_state_type;

endpackage

// File: design/cma_ram.sv
`timescale 1ns / 1ps

module cma_ram #(
   parameter int  WIDTH  = 16,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/cma_div.sv
`timescale 1ns / 1ps

module cma_div #(
   parameter int SUM_W = 22,
   parameter int CNT_W = 7,
   parameter int QUO_W = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] sum,
   input  logic [CNT_W-1:0]        count,
   output logic                    busy,
   output logic [QUO_W-1:0]        quotient
);

   // Rounded mean as (2*|sum| + count) / (2*count), one quotient bit per cycle.
   localparam int NUM_W  = SUM_W + 2;
   localparam int DEN_W  = CNT_W + 1;
   localparam int ITER_W = $clog2(NUM_W + 1);

   logic              busy_ff,  busy_in;
   logic              neg_ff,   neg_in;
   logic [NUM_W-1:0]  num_ff,   num_in;
   logic [DEN_W-1:0]  rem_ff,   rem_in;
   logic [DEN_W-1:0]  den_ff,   den_in;
   logic [ITER_W-1:0] iter_ff,  iter_in;

   logic [SUM_W-1:0]  sum_bits;
   logic [SUM_W-1:0]  mag;
   logic [DEN_W:0]    trial;
   logic              fits;
   logic [NUM_W-1:0]  q_signed;

   // Operand set-up at start, then one restoring step per cycle.
   always_comb begin
      sum_bits = sum;
      mag      = sum[SUM_W-1] ? (SUM_W'(0) - sum_bits) : sum_bits;
      trial    = {rem_ff, num_ff[NUM_W-1]};
      fits     = (trial >= {1'b0, den_ff});

      busy_in = busy_ff;
      neg_in  = neg_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      iter_in = iter_ff;

      if (start) begin
         busy_in = 1'b1;
         neg_in  = sum[SUM_W-1];
         num_in  = {1'b0, mag, 1'b0} + NUM_W'(count);
         rem_in  = '0;
         den_in  = {count, 1'b0};
         iter_in = ITER_W'(NUM_W);
      end else if (busy_ff) begin
         rem_in  = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         num_in  = {num_ff[NUM_W-2:0], fits};
         iter_in = iter_ff - ITER_W'(1);
         busy_in = (iter_ff != ITER_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         iter_ff <= iter_in;
      end
      neg_ff <= neg_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // The sign of the sum goes back on the magnitude of the quotient.
   assign q_signed = neg_ff ? (NUM_W'(0) - num_ff) : num_ff;
   assign quotient = q_signed[QUO_W-1:0];
   assign busy     = busy_ff;

endmodule

// File: design/centered_moving_average.sv
`timescale 1ns / 1ps
// A result for the item that completes its window comes from the serial rounding divider, one
// quotient bit per cycle. After an item that yields a result, no new item is taken until that
// result is in the output register; the flush emits its results one at a time, later if
// rsp_tready stalls.
// Reset is synchronous and active high: it clears the sequence state and the output register
// and sets the window size to 5. The sample memory is not cleared.

module centered_moving_average #(
   parameter int  MAX_WINDOW   = 64,
   parameter int  SAMPLE_WIDTH = 16,
   localparam int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // Window size register.
   input  logic                          csr_wr_en,
   input  logic [cma_pkg::WINDOW_W-1:0]  csr_wr_data,
   // Input items.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [DATA_W-1:0]             req_tdata,   // sample
   input  logic                          req_tlast,   // last_sample
   // Result items.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [DATA_W-1:0]             rsp_tdata,   // average
   output logic                          rsp_tlast    // sequence_done
);

   import cma_pkg::*;

   localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = SAMPLE_WIDTH + PTR_W;
   localparam int CMP_W = (CNT_W > WINDOW_W) ? CNT_W : WINDOW_W;

   cma_state_type                   state_ff, state_in;
   logic [WINDOW_W-1:0]             window_ff, window_in;
   logic signed [SUM_W-1:0]         sum_ff, sum_in;
   logic [PTR_W-1:0]                wp_ff, wp_in;
   logic [CNT_W-1:0]                rc_ff, rc_in;
   logic [CNT_W-1:0]                sis_ff, sis_in;
   logic [CNT_W-1:0]                k_ff, k_in;
   logic                            flag_ff, flag_in;
   logic signed [SAMPLE_WIDTH-1:0]  sample_ff, sample_in;
   logic                            last_ff, last_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]         rsp_avg_ff, rsp_avg_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [CMP_W-1:0]                win_ext;
   logic [CNT_W-1:0]                win_eff, win_low, win_high;

   logic                            rc_full;
   logic signed [SUM_W-1:0]         drop_val;
   logic signed [SUM_W-1:0]         sum_add, sum_sub;
   logic [CNT_W-1:0]                rc_add, high_lim, kfirst, sis_dec;
   logic [CNT_W:0]                  need, need_lim;
   logic                            emit_now, more, remove, rsp_free;
   logic [PTR_W-1:0]                wp_inc;

   logic                            ram_wr_en;
   logic [PTR_W-1:0]                ram_rd_addr;
   logic [SAMPLE_WIDTH-1:0]         ram_rd_data;

   logic                            div_start, div_busy;
   logic signed [SUM_W-1:0]         div_sum;
   logic [CNT_W-1:0]                div_count;
   logic [SAMPLE_WIDTH-1:0]         div_quotient;
   logic                            load_rsp;

   // Store slot that lies the given distance behind the write pointer.
   function automatic logic [PTR_W-1:0] slot_back(input logic [PTR_W-1:0] ptr,
                                                  input logic [CNT_W-1:0] back);
      logic [CNT_W:0] tmp;
      tmp = (CNT_W+1)'(ptr) + (CNT_W+1)'(MAX_WINDOW) - (CNT_W+1)'(back);
      if (tmp >= (CNT_W+1)'(MAX_WINDOW)) begin
         tmp = tmp - (CNT_W+1)'(MAX_WINDOW);
      end
      return PTR_W'(tmp);
   endfunction

   // Effective window, clamped to one through the store depth, and its two halves.
   assign win_ext = CMP_W'(window_ff);

   always_comb begin
      if (win_ext == '0) begin
         win_eff = CNT_W'(1);
      end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
         win_eff = CNT_W'(MAX_WINDOW);
      end else begin
         win_eff = CNT_W'(win_ext);
      end
   end

   assign win_low  = win_eff >> 1;
   assign win_high = win_eff - win_low;

   // Window arithmetic shared by the states.
   always_comb begin
      rc_full  = (rc_ff >= win_eff);
      drop_val = rc_full ? SUM_W'($signed(ram_rd_data)) : SUM_W'(0);
      sum_add  = sum_ff + SUM_W'(sample_ff) - drop_val;
      rc_add   = rc_full ? rc_ff : rc_ff + CNT_W'(1);
      high_lim = (rc_add < win_high) ? rc_add : win_high;
      kfirst   = high_lim - CNT_W'(1);
      emit_now = last_ff || (rc_add >= win_high);
      sum_sub  = sum_ff - SUM_W'($signed(ram_rd_data));
      sis_dec  = sis_ff - CNT_W'(1);
      more     = last_ff && (k_ff != '0);
      need     = {1'b0, k_ff} + {1'b0, win_low};
      need_lim = (need < {1'b0, rc_ff}) ? need : {1'b0, rc_ff};
      remove   = more && ({1'b0, sis_ff} > need_lim);
      rsp_free = !rsp_valid_ff || rsp_tready;
      wp_inc   = (wp_ff == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_ff + PTR_W'(1);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            state_in = emit_now ? ST_WAIT : ST_IDLE;
         end
         ST_WAIT: begin
            if (load_rsp) begin
               if (more) begin
                  state_in = remove ? ST_SUB : ST_WAIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SUB: begin
            state_in = ST_WAIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_tready  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_addr = slot_back(wp_ff, sis_ff);
      div_start   = 1'b0;
      div_sum     = sum_ff;
      div_count   = sis_ff;
      load_rsp    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            ram_rd_addr = slot_back(wp_ff, win_eff);
         end
         ST_ADD: begin
            ram_wr_en = 1'b1;
            div_start = emit_now;
            div_sum   = sum_add;
            div_count = rc_add;
         end
         ST_WAIT: begin
            load_rsp  = !div_busy && rsp_free;
            div_start = !div_busy && rsp_free && more && !remove;
         end
         ST_SUB: begin
            div_start = 1'b1;
            div_sum   = sum_sub;
            div_count = sis_dec;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Next values of the datapath registers.
   always_comb begin
      window_in    = window_ff;
      sum_in       = sum_ff;
      wp_in        = wp_ff;
      rc_in        = rc_ff;
      sis_in       = sis_ff;
      k_in         = k_ff;
      flag_in      = flag_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sample_in = $signed(req_tdata[SAMPLE_WIDTH-1:0]);
               last_in   = req_tlast;
            end
         end
         ST_ADD: begin
            sum_in  = sum_add;
            wp_in   = wp_inc;
            rc_in   = rc_add;
            sis_in  = rc_add;
            k_in    = kfirst;
            flag_in = last_ff && (kfirst == '0);
         end
         ST_WAIT: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = div_quotient;
               rsp_last_in  = flag_ff;
               if (more) begin
                  k_in    = k_ff - CNT_W'(1);
                  flag_in = (k_ff == CNT_W'(1));
               end else if (last_ff) begin
                  sum_in = '0;
                  wp_in  = '0;
                  rc_in  = '0;
                  sis_in = '0;
               end
            end
         end
         ST_SUB: begin
            sum_in = sum_sub;
            sis_in = sis_dec;
         end
         default: begin
            sum_in = sum_ff;
         end
      endcase

      // A new window size starts a fresh sequence.
      if (csr_wr_en) begin
         window_in = csr_wr_data;
         sum_in    = '0;
         wp_in     = '0;
         rc_in     = '0;
         sis_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         sum_ff       <= '0;
         wp_ff        <= '0;
         rc_ff        <= '0;
         sis_ff       <= '0;
         k_ff         <= '0;
         flag_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         sum_ff       <= sum_in;
         wp_ff        <= wp_in;
         rc_ff        <= rc_in;
         sis_ff       <= sis_in;
         k_ff         <= k_in;
         flag_ff      <= flag_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Circular store of the recent samples.
   cma_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (MAX_WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Serial divider for the rounded mean.
   cma_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W),
      .QUO_W (SAMPLE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sum      (div_sum),
      .count    (div_count),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_avg_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: design/cma_checker.sv
`timescale 1ns / 1ps
`include "centered_moving_average_defines.svh"

module cma_checker #(
   parameter int DATA_W = 16
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tlast
);

   // One item at a time: the input closes right after an item is taken.
   `CMA_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "input still open after an item was taken")

   // A result that waits keeps its value.
   `CMA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "waiting result changed or dropped")

   // Reset empties the output register and opens the input.
   `CMA_ASSERT_AFTER_RESET(a_reset_rsp, clock, reset, !rsp_tvalid, "result offered after reset")
   `CMA_ASSERT_AFTER_RESET(a_reset_req, clock, reset, req_tready, "input not ready after reset")

endmodule

bind centered_moving_average cma_checker #(.DATA_W(DATA_W)) u_cma_checker (.*);

// File: test/centered_moving_average_test.sv
`timescale 1ns / 1ps

module centered_moving_average_test;
   import cma_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 97;
   localparam longint LIMIT_CYCLES = 400000;

   typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   // One line of the directed script: a window write or a sample, with an
   // optional hand-written expectation for a sample that yields one result.
   typedef struct {
      row_kind_type       kind;
      logic [15:0]        value;
      bit                 fin;
      bit                 typed;
      logic signed [15:0] want;
   } script_row_type;

   typedef struct {
      logic signed [15:0] average;
      logic               done;
   } mean_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [WINDOW_W-1:0]   csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;    // sample
   logic                  req_tlast = 1'b0;  // last_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;         // average
   logic                  rsp_tlast;         // sequence_done

   // Predictor state: window setting, sample history and running sum.
   logic [WINDOW_W-1:0]   window_reg;
   logic signed [15:0]    history [0:63];
   logic signed [21:0]    running_sum;
   logic [5:0]            wr_slot;
   logic [6:0]            seen_count;
   logic [6:0]            sum_count;

   mean_type              expected_means[$];
   int                    mismatches = 0;
   int                    fed = 0;
   bit                    steady = 1'b0;
   int                    stall_left = 0;

   script_row_type script [0:28] = '{
      // Short sequence with the window size left at its reset value.
      '{ROW_SAMPLE, 16'd10,     1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, -16'sd20,   1'b1, 1'b0, 16'sd0},
      // A window of zero acts as one: every average is the sample itself.
      '{ROW_WRITE,  16'd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'h7fff,   1'b0, 1'b1, 16'sh7fff},
      '{ROW_SAMPLE, 16'h8000,   1'b0, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, 16'h5555,   1'b0, 1'b1, 16'sh5555},
      '{ROW_SAMPLE, 16'haaaa,   1'b1, 1'b1, 16'shaaaa},
      // Window of two: halves round away from zero on both signs.
      '{ROW_WRITE,  16'd2,      1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd1,      1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd2,      1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, -16'sd1,    1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, -16'sd2,    1'b1, 1'b0, 16'sd0},
      // Oversized window clamps to the maximum; all results come at the flush.
      '{ROW_WRITE,  16'd127,    1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'h7fff,   1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'h7fff,   1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'h8000,   1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'h7fff,   1'b1, 1'b0, 16'sd0},
      '{ROW_WRITE,  16'd64,     1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'h8000,   1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'h8000,   1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'h8000,   1'b1, 1'b0, 16'sd0},
      // A window write in the middle of a sequence starts a fresh one.
      '{ROW_WRITE,  16'd5,      1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd100,    1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, -16'sd100,  1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd7,      1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE,  16'd3,      1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, -16'sd5,    1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd6,      1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd7,      1'b1, 1'b0, 16'sd0}
   };

   centered_moving_average dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Effective window length after clamping the register to 1..64.
   function automatic int unsigned span();
      if (window_reg < 1) return 1;
      if (window_reg > 64) return 64;
      return 32'(window_reg);
   endfunction

   function automatic logic [5:0] slot_ago(int unsigned back);
      return wr_slot - back[5:0];
   endfunction

   // Mean rounded to nearest, halves away from zero.
   function automatic logic signed [15:0] rounded_average(logic signed [21:0] total,
                                                          int unsigned count);
      longint t, m, q;
      t = longint'(total);
      m = (t < 0) ? -t : t;
      q = (2 * m + longint'(count)) / (2 * longint'(count));
      return 16'((t < 0) ? -q : q);
   endfunction

   function automatic void restart_window();
      running_sum = '0;
      wr_slot     = '0;
      seen_count  = '0;
      sum_count   = '0;
   endfunction

   // Folds one sample into the window and returns the averages it releases.
   function automatic void average_step(logic signed [15:0] s, bit fin, ref mean_type outs[$]);
      int unsigned w, lo, hi, need, k;
      w  = span();
      lo = w / 2;
      hi = w - lo;
      if (seen_count >= w) begin
         running_sum = running_sum - history[slot_ago(w)];
         sum_count   = 7'(w - 1);
         seen_count  = 7'(w);
      end
      history[wr_slot] = s;
      wr_slot     = wr_slot + 6'd1;
      running_sum = running_sum + s;
      if (seen_count < w) seen_count = seen_count + 7'd1;
      sum_count = seen_count;
      if (!fin) begin
         if (seen_count >= hi)
            outs.push_back('{rounded_average(running_sum, 32'(sum_count)), 1'b0});
         return;
      end
      // The flush shrinks the window from the left, one average per step.
      k = (seen_count < hi) ? 32'(seen_count) : hi;
      while (k > 0) begin
         k--;
         need = k + lo + 1;
         if (need > seen_count) need = 32'(seen_count);
         while (sum_count > need) begin
            running_sum = running_sum - history[slot_ago(32'(sum_count))];
            sum_count   = sum_count - 7'd1;
         end
         outs.push_back('{rounded_average(running_sum, 32'(sum_count)), k == 0});
      end
      restart_window();
   endfunction

   // Idle length: mostly none, sometimes a few cycles, now and then a long one.
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [15:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'h7fff;
      if (r < 20) return 16'h8000;
      if (r < 30) return 16'($urandom_range(0, 8) - 4);
      return 16'($urandom);
   endfunction

   // Waits until every expected average has arrived and the block has gone quiet.
   task automatic settle();
      while (expected_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(logic [WINDOW_W-1:0] v);
      req_tvalid <= 1'b0;
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      window_reg = v;
      restart_window();
   endtask

   // Offers one item and, once it is taken, queues the averages it causes.
   task automatic feed_sample(logic signed [15:0] s, bit fin, bit typed,
                              logic signed [15:0] want, bit hold);
      mean_type outs[$];
      int       gap;
      gap = idle_span();
      if (hold || gap > 0) req_tvalid <= 1'b0;
      if (hold) settle();
      repeat (gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      average_step(s, fin, outs);
      if (typed) expected_means.push_back('{want, fin});
      else foreach (outs[i]) expected_means.push_back(outs[i]);
      fed++;
   endtask

   // Result side back-pressure.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 99) < 20) begin
         rsp_tready <= 1'b0;
         stall_left <= idle_span();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker: each item against the oldest expectation.
   always @(posedge clock) begin
      mean_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_means.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: average %0d done %0b",
                        $signed(rsp_tdata), rsp_tlast);
         end else begin
            got = expected_means.pop_front();
            if (rsp_tdata !== got.average) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("average: expected %0d, actual %0d",
                           got.average, $signed(rsp_tdata));
            end
            if (rsp_tlast !== got.done) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sequence_done: expected %0b, actual %0b", got.done, rsp_tlast);
            end
         end
      end
   end

   initial begin
      int unsigned w, len, nseq, target;
      int          r;
      bit          broken;
      window_reg = WINDOW_RESET;
      restart_window();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed script.
      foreach (script[i]) begin
         if (script[i].kind == ROW_WRITE)
            write_window(script[i].value[WINDOW_W-1:0]);
         else
            feed_sample(script[i].value, script[i].fin, script[i].typed, script[i].want, 1'b0);
      end

      // Random phases: one window setting each, mostly complete sequences.
      target = fed + RANDOM_ITEMS;
      while (fed < target) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            case ($urandom_range(0, 3))
               0: write_window(7'd0);
               1: write_window(7'd1);
               2: write_window(7'd64);
               default: write_window(7'd127);
            endcase
         end else if (r < 30) begin
            write_window(7'($urandom_range(0, 127)));
         end else begin
            write_window(7'($urandom_range(1, 12)));
         end
         steady = ($urandom_range(0, 3) == 0);
         w    = span();
         nseq = $urandom_range(1, 3);
         broken = 1'b0;
         for (int q = 0; q < nseq && !broken && fed < target; q++) begin
            if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 2);
            else len = $urandom_range(1, (w + 4 < 40) ? w + 4 : 40);
            // The final sequence ends where the item budget runs out.
            if (len > target - fed) len = target - fed;
            // Now and then the sequence is cut short by the next window write.
            broken = (q == nseq - 1) && ($urandom_range(0, 99) < 15);
            for (int i = 0; i < len; i++)
               feed_sample(pick_sample(), !broken && i == len - 1, 1'b0, 16'sd0,
                           $urandom_range(0, 99) < 6);
         end
      end

      // Drain and report.
      req_tvalid <= 1'b0;
      settle();
      if (mismatches == 0 && expected_means.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #(LIMIT_CYCLES * 12);
      $display("simulation failed");
      $finish;
   end

endmodule
